>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> rtl/sat_pkg.sv
`default_nettype none
package sat_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int VALUE_BITS = 16;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int DIM_W  = 7;
    localparam int CNT_W  = ADDR_W + 1;
    localparam int TBL_W  = 29;
    localparam int SUM_W  = 28;
    localparam int FLD_W  = 6;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_RESTART = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_QUERY = 2'd1;
    localparam logic [1:0] STAT_LOAD_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_ERROR
    } op_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // For a load: addr[0] is the entry above, addr[1] the entry written;
    // use_term[0..2] enable the above, left and above-left terms.
    // For a query: addr[0..3] are the four corners in the order
    // bottom-right, above-right, bottom-left, above-left.
    typedef struct packed {
        op_kind_t                     kind;
        logic [1:0]                   status;
        logic signed [TBL_W-1:0]      value;
        logic [3:0][ADDR_W-1:0]       addr;
        logic [3:0]                   use_term;
    } sat_entry_t;

endpackage
`default_nettype wire

>>> rtl/sat_front.sv
`default_nettype none
module sat_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [sat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sat_pkg::DIM_W-1:0]      cfg_wdata,
    input  wire logic                           in_accept,
    input  wire logic [1:0]                     mode,
    input  wire logic signed [sat_pkg::VALUE_BITS-1:0] value,
    input  wire logic [sat_pkg::FLD_W-1:0]      row_top,
    input  wire logic [sat_pkg::FLD_W-1:0]      col_left,
    input  wire logic [sat_pkg::FLD_W-1:0]      row_bottom,
    input  wire logic [sat_pkg::FLD_W-1:0]      col_right,
    output sat_pkg::sat_entry_t                 entry
);
    import sat_pkg::*;

    logic [DIM_W-1:0] grid_rows_reg, grid_cols_reg;
    logic [DIM_W-1:0] load_row_reg, load_row_next;
    logic [COL_W-1:0] load_col_reg, load_col_next;
    logic [CNT_W-1:0] loaded_cnt_reg, loaded_cnt_next;

    logic [DIM_W-1:0] rows, cols;
    logic [DIM_W-1:0] r;
    logic [COL_W-1:0] c;
    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] lin_idx;
    logic [ROW_W-1:0] rt_m1;
    logic [COL_W-1:0] cl_m1;
    logic             query_bad;

    always_comb begin
        if (grid_rows_reg == '0) begin
            rows = DIM_W'(1);
        end else if (grid_rows_reg > DIM_W'(MAX_ROWS)) begin
            rows = DIM_W'(MAX_ROWS);
        end else begin
            rows = grid_rows_reg;
        end
        if (grid_cols_reg == '0) begin
            cols = DIM_W'(1);
        end else if (grid_cols_reg > DIM_W'(MAX_COLS)) begin
            cols = DIM_W'(MAX_COLS);
        end else begin
            cols = grid_cols_reg;
        end
    end

    always_comb begin
        // A restart places the item at the top-left corner with an empty table.
        if (mode == MODE_RESTART) begin
            r        = '0;
            c        = '0;
            cnt_base = '0;
        end else begin
            r        = load_row_reg;
            c        = load_col_reg;
            cnt_base = loaded_cnt_reg;
        end
        lin_idx = CNT_W'(CNT_W'(row_bottom) * CNT_W'(cols)) + CNT_W'(col_right);
        rt_m1   = ROW_W'(row_top - 1'b1);
        cl_m1   = COL_W'(col_left - 1'b1);
        query_bad = (row_top > row_bottom) || (col_left > col_right) ||
                    (DIM_W'(row_bottom) >= rows) || (DIM_W'(col_right) >= cols) ||
                    (lin_idx >= loaded_cnt_reg);

        load_row_next   = load_row_reg;
        load_col_next   = load_col_reg;
        loaded_cnt_next = loaded_cnt_reg;

        entry.kind     = OP_ERROR;
        entry.status   = STAT_BAD_QUERY;
        entry.value    = TBL_W'(value);
        entry.addr     = '0;
        entry.use_term = '0;

        unique case (mode)
            MODE_LOAD, MODE_RESTART: begin
                if (r >= rows || DIM_W'(c) >= cols) begin
                    entry.status = STAT_LOAD_FULL;
                    if (mode == MODE_RESTART) begin
                        load_row_next   = '0;
                        load_col_next   = '0;
                        loaded_cnt_next = '0;
                    end
                end else begin
                    entry.kind        = OP_LOAD;
                    entry.status      = STAT_OK;
                    entry.addr[0]     = {ROW_W'(r - 1'b1), c};
                    entry.addr[1]     = {ROW_W'(r), c};
                    entry.use_term[0] = (r != '0);
                    entry.use_term[1] = (c != '0);
                    entry.use_term[2] = (r != '0) && (c != '0);
                    loaded_cnt_next   = cnt_base + 1'b1;
                    if (DIM_W'(c) + 1'b1 >= cols) begin
                        load_col_next = '0;
                        load_row_next = r + 1'b1;
                    end else begin
                        load_col_next = c + 1'b1;
                        load_row_next = r;
                    end
                end
            end
            MODE_QUERY: begin
                if (!query_bad) begin
                    entry.kind        = OP_QUERY;
                    entry.status      = STAT_OK;
                    entry.addr[0]     = {ROW_W'(row_bottom), COL_W'(col_right)};
                    entry.addr[1]     = {rt_m1, COL_W'(col_right)};
                    entry.addr[2]     = {ROW_W'(row_bottom), cl_m1};
                    entry.addr[3]     = {rt_m1, cl_m1};
                    entry.use_term[0] = 1'b1;
                    entry.use_term[1] = (row_top != '0);
                    entry.use_term[2] = (col_left != '0);
                    entry.use_term[3] = (row_top != '0) && (col_left != '0);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg  <= DIM_W'(MAX_ROWS);
            grid_cols_reg  <= DIM_W'(MAX_COLS);
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            loaded_cnt_reg <= '0;
        end else if (cfg_wr_en) begin
            // A shape change restarts loading so that stale entries stay hidden.
            if (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLS) begin
                if (cfg_index == REG_GRID_ROWS) begin
                    grid_rows_reg <= cfg_wdata;
                end else begin
                    grid_cols_reg <= cfg_wdata;
                end
                load_row_reg   <= '0;
                load_col_reg   <= '0;
                loaded_cnt_reg <= '0;
            end
        end else if (in_accept) begin
            load_row_reg   <= load_row_next;
            load_col_reg   <= load_col_next;
            loaded_cnt_reg <= loaded_cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/sat_queue.sv
`default_nettype none
module sat_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire sat_pkg::sat_entry_t din,
    input  wire logic          pop,
    output sat_pkg::sat_entry_t dout,
    output logic               full,
    output logic               empty
);
    import sat_pkg::*;

    sat_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/sat_back.sv
`default_nettype none
module sat_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire sat_pkg::sat_entry_t        q_dout,
    input  wire logic                       q_empty,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [sat_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                      m_tuser
);
    import sat_pkg::*;

    logic signed [TBL_W-1:0] mem [DEPTH];

    back_state_t             state_reg, state_next;
    sat_entry_t              cur_reg, cur_next;
    logic [2:0]              step_reg, step_next;
    logic signed [TBL_W-1:0] acc_reg, acc_next;
    logic signed [TBL_W-1:0] left_reg, left_next;
    logic signed [TBL_W-1:0] al_reg, al_next;
    logic signed [TBL_W-1:0] rd_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0] out_sum_reg, out_sum_next;
    logic [1:0]              out_status_reg, out_status_next;

    logic                    out_free;
    logic                    finish;
    logic                    mem_rd_en, mem_we;
    logic [ADDR_W-1:0]       mem_addr;
    logic signed [TBL_W-1:0] mem_wdata;
    logic signed [TBL_W-1:0] above;
    logic signed [TBL_W-1:0] load_sum;
    logic signed [TBL_W-1:0] res_sum;
    logic [1:0]              res_status;

    // Corner k of a query enters with + for the two diagonal corners, - otherwise.
    function automatic logic signed [TBL_W-1:0] corner_term(
        input logic signed [TBL_W-1:0] data,
        input logic                    use_it,
        input logic [1:0]              k
    );
        logic signed [TBL_W-1:0] t;
        t = use_it ? data : '0;
        if (k == 2'd1 || k == 2'd2) begin
            t = -t;
        end
        return t;
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(unsigned'(out_sum_reg));
    assign m_tuser  = out_status_reg;

    always_comb begin
        above    = cur_reg.use_term[0] ? rd_data_reg : '0;
        load_sum = cur_reg.value + above
                 + (cur_reg.use_term[1] ? left_reg : TBL_W'(0))
                 - (cur_reg.use_term[2] ? al_reg : TBL_W'(0));
    end

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        al_next         = al_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sum_next    = out_sum_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        finish          = 1'b0;
        mem_rd_en       = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = cur_reg.addr[step_reg[1:0]];
        mem_wdata       = load_sum;
        res_sum         = '0;
        res_status      = cur_reg.status;

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cur_next   = q_dout;
                    step_next  = '0;
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                unique case (cur_reg.kind)
                    OP_LOAD: begin
                        if (step_reg == 3'd0) begin
                            mem_rd_en = 1'b1;
                            step_next = 3'd1;
                        end else if (out_free) begin
                            finish    = 1'b1;
                            mem_we    = 1'b1;
                            mem_addr  = cur_reg.addr[1];
                            left_next = load_sum;
                            al_next   = above;
                            res_sum   = load_sum;
                        end
                    end
                    OP_QUERY: begin
                        // Reads go out on steps 0..3; step k+1 adds in the corner that step k read.
                        if (step_reg != 3'd4) begin
                            mem_rd_en = 1'b1;
                            step_next = step_reg + 1'b1;
                            if (step_reg == 3'd0) begin
                                acc_next = '0;
                            end else begin
                                acc_next = acc_reg + corner_term(rd_data_reg,
                                    cur_reg.use_term[2'(step_reg - 1'b1)],
                                    2'(step_reg - 1'b1));
                            end
                        end else if (out_free) begin
                            finish  = 1'b1;
                            res_sum = acc_reg + corner_term(rd_data_reg,
                                cur_reg.use_term[3], 2'd3);
                        end
                    end
                    OP_ERROR: begin
                        if (out_free) begin
                            finish = 1'b1;
                        end
                    end
                    default: begin
                        state_next = BK_IDLE;
                    end
                endcase
                if (finish) begin
                    out_valid_next  = 1'b1;
                    out_sum_next    = SUM_W'(res_sum);
                    out_status_next = res_status;
                    if (!q_empty) begin
                        q_pop     = 1'b1;
                        cur_next  = q_dout;
                        step_next = '0;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_rd_en) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        step_reg       <= step_next;
        acc_reg        <= acc_next;
        left_reg       <= left_next;
        al_reg         <= al_next;
        out_sum_reg    <= out_sum_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/summed_area_table_rect_sum_top.sv
// Channel  | Dir | Handshake         | Payload
// s_       | in  | s_tvalid/s_tready | tuser: mode; tdata: value, corners
// m_       | out | m_tvalid/m_tready | tuser: status; tdata: sum
// cfg_     | in  | cfg_wr_en         | cfg_index, cfg_wdata (grid_rows, grid_cols)
//
// The front classifies an item in the cycle it is accepted and queues it.
// The back runs the single-port table: a load reads the entry above, then
// writes; a query does four reads, one landing per cycle, then sums them; an
// error item just reports its status. The table port sets the rate.
// aresetn is synchronous; the table itself is not cleared and needs no sweep.
// s_tready drops only when the four-entry queue is full; a stalled m_ side
// holds the back at its final step.
`default_nettype none
`include "assert_macros.svh"
module summed_area_table_rect_sum_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [15:0] value, [21:16] row_top, [27:22] col_left,
    // [33:28] row_bottom, [39:34] col_right
    input  wire logic [sat_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [27:0] sum, upper bits zero
    output logic [sat_pkg::M_TDATA_W-1:0]       m_tdata,
    // [1:0] status
    output logic [1:0]                          m_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic [sat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sat_pkg::DIM_W-1:0]      cfg_wdata
);
    import sat_pkg::*;

    sat_entry_t front_entry;
    sat_entry_t q_dout;
    logic       q_full, q_empty, q_pop;
    logic       in_accept;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    sat_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_accept  (in_accept),
        .mode       (s_tuser),
        .value      (s_tdata[15:0]),
        .row_top    (s_tdata[21:16]),
        .col_left   (s_tdata[27:22]),
        .row_bottom (s_tdata[33:28]),
        .col_right  (s_tdata[39:34]),
        .entry      (front_entry)
    );

    sat_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (in_accept),
        .din     (front_entry),
        .pop     (q_pop),
        .dout    (q_dout),
        .full    (q_full),
        .empty   (q_empty)
    );

    sat_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_dout   (q_dout),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `ASSERT_NEVER(a_pop_when_empty, aclk, aresetn, q_pop && q_empty)
    `ASSERT_PROP(a_err_sum_zero, aclk, aresetn, (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == '0))
    `ASSERT_PROP(a_status_code, aclk, aresetn, m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_BAD_QUERY || m_tuser == STAT_LOAD_FULL))
    `ASSERT_PROP(a_ready_tracks_queue, aclk, aresetn, (in_accept && !q_pop && !q_empty) |=> !q_empty)

endmodule
`default_nettype wire

>>> bench/summed_area_table_rect_sum_top_tb.sv
`timescale 1ns / 1ps
module summed_area_table_rect_sum_top_tb;
    import sat_pkg::*;

    localparam logic [1:0]           MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3  = 2'd3;
    localparam int                   RANDOM_ITEMS = 600;

    typedef struct {
        logic [1:0]            mode;
        logic [VALUE_BITS-1:0] value;
        logic [FLD_W-1:0]      row_top;
        logic [FLD_W-1:0]      col_left;
        logic [FLD_W-1:0]      row_bottom;
        logic [FLD_W-1:0]      col_right;
    } sat_item_t;

    typedef struct {
        logic [SUM_W-1:0] sum;
        logic [1:0]       status;
    } rect_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    wire                  s_tready;
    // [15:0] value, [21:16] row_top, [27:22] col_left,
    // [33:28] row_bottom, [39:34] col_right
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    // [1:0] mode
    logic [1:0]           s_tuser   = '0;
    wire                  m_tvalid;
    logic                 m_tready  = 1'b0;
    // [27:0] sum, upper bits zero
    wire [M_TDATA_W-1:0]  m_tdata;
    // [1:0] status
    wire [1:0]            m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;

    // Shadow of the block: table, load position and grid registers.
    logic signed [TBL_W-1:0] prefix_mem [DEPTH];
    logic [DIM_W-1:0]        rows_reg       = 7'd64;
    logic [DIM_W-1:0]        cols_reg       = 7'd64;
    int                      load_r         = 0;
    int                      load_c         = 0;
    int                      loaded_n       = 0;
    longint                  left_acc       = 0;
    longint                  above_left_acc = 0;

    sat_item_t    grid_items [$];
    rect_result_t sums_due [$];
    int           fail_cnt   = 0;
    int           gen_loaded = 0;
    int           send_gap   = 0;
    int           sink_hold  = 0;
    logic         idle_free  = 1'b0;
    logic         in_fire    = 1'b0;

    summed_area_table_rect_sum_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int dim_clamp(input int v, input int maxv);
        return (v < 1) ? 1 : ((v > maxv) ? maxv : v);
    endfunction

    function automatic void rewind_load();
        load_r         = 0;
        load_c         = 0;
        loaded_n       = 0;
        left_acc       = 0;
        above_left_acc = 0;
    endfunction

    // Applies one item to the shadow state and returns the result it should cause.
    function automatic rect_result_t sat_step(input logic [1:0] mode,
                                              input logic [S_TDATA_W-1:0] d);
        rect_result_t res;
        int           rows, cols, rt, cl, rb, cr;
        longint       above, acc;
        rows = dim_clamp(int'(rows_reg), MAX_ROWS);
        cols = dim_clamp(int'(cols_reg), MAX_COLS);
        rt = int'(d[21:16]);
        cl = int'(d[27:22]);
        rb = int'(d[33:28]);
        cr = int'(d[39:34]);
        res.sum = '0;
        res.status = STAT_OK;
        if (mode == MODE_LOAD || mode == MODE_RESTART) begin
            if (mode == MODE_RESTART)
                rewind_load();
            if (load_r >= rows) begin
                res.status = STAT_LOAD_FULL;
            end else begin
                above = (load_r > 0) ?
                        longint'(prefix_mem[(load_r - 1) * MAX_COLS + load_c]) : 0;
                acc = longint'($signed(d[VALUE_BITS-1:0])) + above;
                if (load_c > 0)
                    acc += left_acc;
                if (load_r > 0 && load_c > 0)
                    acc -= above_left_acc;
                prefix_mem[load_r * MAX_COLS + load_c] = TBL_W'(acc);
                left_acc = acc;
                above_left_acc = above;
                loaded_n++;
                if (load_c + 1 >= cols) begin
                    load_c = 0;
                    load_r++;
                end else begin
                    load_c++;
                end
                res.sum = acc[SUM_W-1:0];
            end
        end else if (mode == MODE_QUERY) begin
            // The bottom-right corner is last in raster order, so checking it
            // against the load count covers all four corners.
            if (rt > rb || cl > cr || rb >= rows || cr >= cols ||
                rb * cols + cr >= loaded_n) begin
                res.status = STAT_BAD_QUERY;
            end else begin
                acc = longint'(prefix_mem[rb * MAX_COLS + cr]);
                if (rt > 0)
                    acc -= longint'(prefix_mem[(rt - 1) * MAX_COLS + cr]);
                if (cl > 0)
                    acc -= longint'(prefix_mem[rb * MAX_COLS + cl - 1]);
                if (rt > 0 && cl > 0)
                    acc += longint'(prefix_mem[(rt - 1) * MAX_COLS + cl - 1]);
                res.sum = acc[SUM_W-1:0];
            end
        end else begin
            res.status = STAT_BAD_QUERY;
        end
        return res;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VALUE_BITS-1:0] rnd_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [FLD_W-1:0] rnd_field();
        return FLD_W'($urandom_range(0, 63));
    endfunction

    function automatic sat_item_t mk_item(input logic [1:0] mode,
                                          input logic [VALUE_BITS-1:0] value,
                                          input logic [FLD_W-1:0] rt,
                                          input logic [FLD_W-1:0] cl,
                                          input logic [FLD_W-1:0] rb,
                                          input logic [FLD_W-1:0] cr);
        sat_item_t it;
        it.mode = mode;
        it.value = value;
        it.row_top = rt;
        it.col_left = cl;
        it.row_bottom = rb;
        it.col_right = cr;
        return it;
    endfunction

    // Tracks how much of the grid is loaded so that queries can aim inside it.
    task automatic queue_item(input sat_item_t it);
        int cells;
        cells = dim_clamp(int'(rows_reg), MAX_ROWS) * dim_clamp(int'(cols_reg), MAX_COLS);
        if (it.mode == MODE_RESTART)
            gen_loaded = 1;
        else if (it.mode == MODE_LOAD && gen_loaded < cells)
            gen_loaded++;
        grid_items.push_back(it);
    endtask

    task automatic write_grid_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_GRID_ROWS) begin
            rows_reg = val;
            rewind_load();
            gen_loaded = 0;
        end else if (idx == REG_GRID_COLS) begin
            cols_reg = val;
            rewind_load();
            gen_loaded = 0;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (grid_items.size() != 0 || sums_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Input side: the handshake is seen at the rising edge, new items go out
    // at the falling edge.
    always @(negedge aclk) begin : feed_drive
        logic nxt_valid;
        if (in_fire) begin
            void'(grid_items.pop_front());
            send_gap = idle_free ? 0 : gap_len();
        end
        nxt_valid = s_tvalid && !in_fire;
        if (!nxt_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (aresetn && grid_items.size() > 0) begin
                nxt_valid = 1'b1;
                s_tdata <= {grid_items[0].col_right, grid_items[0].row_bottom,
                            grid_items[0].col_left, grid_items[0].row_top,
                            grid_items[0].value};
                s_tuser <= grid_items[0].mode;
            end
        end
        s_tvalid <= nxt_valid;
    end

    always @(negedge aclk) begin : sink_drive
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!idle_free && $urandom_range(0, 3) == 0)
                sink_hold = gap_len();
        end
    end

    always @(posedge aclk) begin : result_check
        rect_result_t want;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            sums_due.push_back(sat_step(s_tuser, s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (sums_due.size() == 0) begin
                $error("result with none outstanding: sum %0d status %0d",
                       $signed(m_tdata[SUM_W-1:0]), m_tuser);
                fail_cnt++;
            end else begin
                want = sums_due.pop_front();
                if (m_tdata[SUM_W-1:0] !== want.sum) begin
                    $error("sum: expected %0d, got %0d",
                           $signed(want.sum), $signed(m_tdata[SUM_W-1:0]));
                    fail_cnt++;
                end
                if (m_tdata[M_TDATA_W-1:SUM_W] !== '0) begin
                    $error("tdata padding: expected 0, got %0h",
                           m_tdata[M_TDATA_W-1:SUM_W]);
                    fail_cnt++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        int shape, pick, prefill, burst, k, idx, rb_i, cr_i;
        int r_set, c_set, cols_eff, cells, rand_total;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset shape is 64 x 64.
        queue_item(mk_item(MODE_QUERY, 16'h0000, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_UNUSED, 16'hFFFF, 6'd63, 6'd63, 6'd63, 6'd63));
        queue_item(mk_item(MODE_LOAD, 16'h7FFF, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_LOAD, 16'h8000, 6'd63, 6'd63, 6'd63, 6'd63));
        queue_item(mk_item(MODE_LOAD, 16'h0001, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_QUERY, 16'h0000, 6'd0, 6'd0, 6'd0, 6'd2));
        queue_item(mk_item(MODE_QUERY, 16'h0000, 6'd1, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_QUERY, 16'h0000, 6'd0, 6'd2, 6'd0, 6'd1));
        queue_item(mk_item(MODE_QUERY, 16'h0000, 6'd0, 6'd0, 6'd0, 6'd63));
        queue_item(mk_item(MODE_RESTART, 16'h0005, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_QUERY, 16'hFFFF, 6'd0, 6'd0, 6'd0, 6'd0));
        wait_idle();

        // A 2 x 3 grid filled to the end, then one load too many.
        write_grid_reg(REG_GRID_ROWS, 7'd2);
        write_grid_reg(REG_GRID_COLS, 7'd3);
        write_grid_reg(REG_SPARE_2, 7'd127);
        write_grid_reg(REG_SPARE_3, 7'd0);
        @(posedge aclk);
        queue_item(mk_item(MODE_LOAD, 16'hFFF9, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_LOAD, 16'h7FFF, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_LOAD, 16'h8000, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_LOAD, 16'h0064, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_LOAD, 16'h7FFF, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_LOAD, 16'hFFFF, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_LOAD, 16'h1234, 6'd0, 6'd0, 6'd0, 6'd0));
        queue_item(mk_item(MODE_QUERY, 16'h0000, 6'd0, 6'd0, 6'd1, 6'd2));
        queue_item(mk_item(MODE_QUERY, 16'h0000, 6'd1, 6'd1, 6'd1, 6'd2));
        queue_item(mk_item(MODE_QUERY, 16'h0000, 6'd0, 6'd0, 6'd2, 6'd0));
        queue_item(mk_item(MODE_QUERY, 16'h0000, 6'd0, 6'd0, 6'd0, 6'd3));
        wait_idle();

        // The first two shapes are a single column of 64 and a single row of
        // 64 (the second from register values that clamp), so the corner fields reach 63.
        shape = 0;
        rand_total = 0;
        while (rand_total < RANDOM_ITEMS) begin
            case (shape)
                0: begin
                    r_set = 64;
                    c_set = 1;
                end
                1: begin
                    r_set = 0;
                    c_set = 127;
                end
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6) begin
                        r_set = $urandom_range(1, 8);
                        c_set = $urandom_range(1, 8);
                    end else if (pick < 8) begin
                        r_set = $urandom_range(0, 127);
                        c_set = $urandom_range(0, 127);
                    end else begin
                        r_set = $urandom_range(1, 3);
                        c_set = 64;
                    end
                end
            endcase
            idle_free = (shape % 4 == 3);
            write_grid_reg(REG_GRID_ROWS, DIM_W'(r_set));
            write_grid_reg(REG_GRID_COLS, DIM_W'(c_set));
            if ($urandom_range(0, 4) == 0)
                write_grid_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                               DIM_W'($urandom));
            cols_eff = dim_clamp(int'(cols_reg), MAX_COLS);
            cells = dim_clamp(int'(rows_reg), MAX_ROWS) * cols_eff;
            @(posedge aclk);

            prefill = (cells <= 64) ? cells + $urandom_range(0, 2) : $urandom_range(1, 24);
            for (k = 0; k < prefill; k++)
                queue_item(mk_item((k == 0 && $urandom_range(0, 1) == 1) ?
                                   MODE_RESTART : MODE_LOAD,
                                   rnd_value(), rnd_field(), rnd_field(),
                                   rnd_field(), rnd_field()));

            burst = $urandom_range(30, 60);
            for (k = 0; k < burst; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35 && gen_loaded == cells && $urandom_range(0, 2) != 0)
                    pick = 36;
                if (pick < 35 || gen_loaded == 0) begin
                    queue_item(mk_item(MODE_LOAD, rnd_value(), rnd_field(), rnd_field(),
                                       rnd_field(), rnd_field()));
                end else if (pick < 40) begin
                    queue_item(mk_item(MODE_RESTART, rnd_value(), rnd_field(),
                                       rnd_field(), rnd_field(), rnd_field()));
                end else if (pick < 88) begin
                    idx = $urandom_range(0, gen_loaded - 1);
                    rb_i = idx / cols_eff;
                    cr_i = idx % cols_eff;
                    queue_item(mk_item(MODE_QUERY, rnd_value(),
                                       FLD_W'($urandom_range(0, rb_i)),
                                       FLD_W'($urandom_range(0, cr_i)),
                                       FLD_W'(rb_i), FLD_W'(cr_i)));
                end else begin
                    queue_item(mk_item(2'($urandom_range(0, 3)), rnd_value(), rnd_field(),
                                       rnd_field(), rnd_field(), rnd_field()));
                end
            end
            rand_total += prefill + burst;
            shape++;
            wait_idle();
        end

        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> summed_area_table_rect_sum_top.f
+incdir+rtl
rtl/sat_pkg.sv
rtl/sat_front.sv
rtl/sat_queue.sv
rtl/sat_back.sv
rtl/summed_area_table_rect_sum_top.sv
bench/summed_area_table_rect_sum_top_tb.sv
